FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL of this project.
// The clock is always clk and the reset is always rst_n, active low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed")

// Checked at every clock edge, including during reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed")

`else

`define ASSERT_CHK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: sv/krsp_pkg.sv
package krsp_pkg;

  // Default key length limit; the counter saturates at the smaller of this and 65535.
  localparam logic [31:0] MAX_KEY_LENGTH_DEF = 32'd65535;

  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_CATEGORY_PRESENT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMESTAMP_PRESENT = 2'd1;

  typedef enum logic [3:0] {
    PH_ID  = 4'b0001,
    PH_CAT = 4'b0010,
    PH_TS  = 4'b0100,
    PH_KEY = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
  } in_payload_t;

  typedef struct packed {
    logic [31:0]        record_id;
    logic [15:0]        category;
    logic signed [31:0] timestamp;
    logic [7:0]         key_byte;
    logic [15:0]        key_length;
    logic               record_end;
  } out_payload_t;

endpackage

FILE: sv/key_record_stream_parser_core.sv
// A result appears on out_* in the cycle after the key byte that causes it is accepted.
// Throughput: one byte per cycle while in_stall is low; header bytes are consumed without a result.
// in_stall rises only while the result register holds a transaction that the sink stalls.
// Reset (synchronous, rst_n low) returns the parser to the first id byte, clears the held
// fields and the key count, clears both configuration bits and empties the result register.
`include "assert_macros.svh"

module key_record_stream_parser_core #(
  parameter logic [31:0] MAX_KEY_LENGTH = krsp_pkg::MAX_KEY_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  krsp_pkg::in_payload_t               in_payload,
  output logic                                out_valid,
  input  logic                                out_stall,
  output krsp_pkg::out_payload_t              out_payload,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [krsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic                                cfg_wdata
);

  localparam logic [15:0] KEY_CAP =
    (MAX_KEY_LENGTH < 32'd65535) ? MAX_KEY_LENGTH[15:0] : 16'hFFFF;

  logic                   cat_present_r;
  logic                   ts_present_r;
  krsp_pkg::phase_t       phase_r, phase_nxt, phase_cur;
  logic [1:0]             idx_r, idx_nxt, idx_cur;
  logic [31:0]            id_r, id_nxt;
  logic [15:0]            cat_r, cat_nxt;
  logic [31:0]            ts_r, ts_nxt;
  logic [15:0]            kc_r, kc_nxt, kc_cur;
  logic                   emit;
  logic                   in_acc;
  logic                   out_valid_r;
  krsp_pkg::out_payload_t out_payload_r, out_payload_nxt;
  logic [7:0]             b;

  assign cfg_ready   = 1'b1;
  assign in_stall    = out_valid_r && out_stall;
  assign in_acc      = in_valid && !in_stall;
  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;
  assign b           = in_payload.data_byte;

  // A buffer start drops any partial record before the byte is parsed.
  assign phase_cur = in_payload.buffer_start ? krsp_pkg::PH_ID : phase_r;
  assign idx_cur   = in_payload.buffer_start ? 2'd0 : idx_r;
  assign kc_cur    = in_payload.buffer_start ? 16'd0 : kc_r;

  always_comb begin
    phase_nxt       = phase_cur;
    idx_nxt         = idx_cur;
    id_nxt          = id_r;
    cat_nxt         = cat_r;
    ts_nxt          = ts_r;
    kc_nxt          = kc_cur;
    emit            = 1'b0;
    out_payload_nxt = out_payload_r;
    case (phase_cur)
      krsp_pkg::PH_ID: begin
        if (idx_cur == 2'd0) begin
          // First id byte opens a new record, so absent fields read as zero.
          id_nxt  = {24'd0, b};
          cat_nxt = 16'd0;
          ts_nxt  = 32'd0;
          kc_nxt  = 16'd0;
        end else begin
          id_nxt[8*idx_cur +: 8] = b;
        end
        if (idx_cur == 2'd3) begin
          idx_nxt = 2'd0;
          if (cat_present_r) begin
            phase_nxt = krsp_pkg::PH_CAT;
          end else if (ts_present_r) begin
            phase_nxt = krsp_pkg::PH_TS;
          end else begin
            phase_nxt = krsp_pkg::PH_KEY;
          end
        end else begin
          idx_nxt = idx_cur + 2'd1;
        end
      end
      krsp_pkg::PH_CAT: begin
        cat_nxt[8*idx_cur[0] +: 8] = b;
        if (idx_cur[0]) begin
          idx_nxt   = 2'd0;
          phase_nxt = ts_present_r ? krsp_pkg::PH_TS : krsp_pkg::PH_KEY;
        end else begin
          idx_nxt = 2'd1;
        end
      end
      krsp_pkg::PH_TS: begin
        ts_nxt[8*idx_cur +: 8] = b;
        if (idx_cur == 2'd3) begin
          idx_nxt   = 2'd0;
          phase_nxt = krsp_pkg::PH_KEY;
        end else begin
          idx_nxt = idx_cur + 2'd1;
        end
      end
      krsp_pkg::PH_KEY: begin
        emit = 1'b1;
        if (b != 8'd0 && kc_cur < KEY_CAP) begin
          kc_nxt = kc_cur + 16'd1;
        end
        out_payload_nxt.record_id  = id_r;
        out_payload_nxt.category   = cat_r;
        out_payload_nxt.timestamp  = ts_r;
        out_payload_nxt.key_byte   = b;
        out_payload_nxt.key_length = (b != 8'd0 && kc_cur < KEY_CAP) ? kc_cur + 16'd1 : kc_cur;
        out_payload_nxt.record_end = (b == 8'd0);
        if (b == 8'd0) begin
          phase_nxt = krsp_pkg::PH_ID;
          idx_nxt   = 2'd0;
          kc_nxt    = 16'd0;
        end
      end
      default: begin
        phase_nxt = krsp_pkg::PH_ID;
        idx_nxt   = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cat_present_r <= 1'b0;
      ts_present_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        krsp_pkg::CFG_CATEGORY_PRESENT:  cat_present_r <= cfg_wdata;
        krsp_pkg::CFG_TIMESTAMP_PRESENT: ts_present_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= krsp_pkg::PH_ID;
      idx_r   <= 2'd0;
      id_r    <= 32'd0;
      cat_r   <= 16'd0;
      ts_r    <= 32'd0;
      kc_r    <= 16'd0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      id_r    <= id_nxt;
      cat_r   <= cat_nxt;
      ts_r    <= ts_nxt;
      kc_r    <= kc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_payload_r <= out_payload_nxt;
    end
  end

  `ASSERT_ALWAYS(a_stall_needs_result, in_stall |-> out_valid_r);
  `ASSERT_CHK(a_end_has_zero_byte,
              out_valid_r && out_payload_r.record_end |-> out_payload_r.key_byte == 8'd0);
  `ASSERT_CHK(a_length_capped, out_valid_r |-> out_payload_r.key_length <= KEY_CAP);
  `ASSERT_CHK(a_end_restarts_id,
              in_acc && phase_cur == krsp_pkg::PH_KEY && b == 8'd0
              |=> phase_r == krsp_pkg::PH_ID && idx_r == 2'd0 && kc_r == 16'd0);
  `ASSERT_CHK(a_header_silent,
              in_acc && phase_cur != krsp_pkg::PH_KEY |=> !out_valid_r);

endmodule

FILE: sim/key_record_stream_parser_core_tb.sv
module key_record_stream_parser_core_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 5;
  localparam int BYTES_PER_PHASE = 150;
  localparam int RX_HOLD_CYCLES = 200;
  localparam logic [15:0] KEY_CAP =
    (krsp_pkg::MAX_KEY_LENGTH_DEF < 32'd65535) ? 16'(krsp_pkg::MAX_KEY_LENGTH_DEF) : 16'hFFFF;
  localparam logic [krsp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [krsp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  krsp_pkg::in_payload_t in_payload = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  krsp_pkg::out_payload_t out_payload;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [krsp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic cfg_wdata = 1'b0;

  key_record_stream_parser_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_payload(out_payload),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Byte stream waiting to be offered, and key results still owed by the parser.
  krsp_pkg::in_payload_t  stream_bytes[$];
  krsp_pkg::out_payload_t key_results_due[$];

  // Parser state mirrored by the testbench.
  krsp_pkg::phase_t ps_phase;
  logic [1:0]  ps_idx;
  logic [31:0] ps_id;
  logic [15:0] ps_cat;
  logic [31:0] ps_ts;
  logic [15:0] ps_count;
  bit          cat_on;
  bit          ts_on;

  bit no_gaps = 1'b0;
  int bytes_taken = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int settings_used = 0;

  task automatic parse_byte(input krsp_pkg::in_payload_t item);
    krsp_pkg::out_payload_t r;
    logic [7:0] b;
    b = item.data_byte;
    if (item.buffer_start) begin
      ps_phase = krsp_pkg::PH_ID;
      ps_idx = 2'd0;
      ps_count = 16'd0;
    end
    case (ps_phase)
      krsp_pkg::PH_ID: begin
        if (ps_idx == 2'd0) begin
          ps_id = '0;
          ps_cat = '0;
          ps_ts = '0;
          ps_count = '0;
        end
        ps_id[8*ps_idx +: 8] = b;
        if (ps_idx == 2'd3) begin
          ps_idx = 2'd0;
          ps_phase = cat_on ? krsp_pkg::PH_CAT : (ts_on ? krsp_pkg::PH_TS : krsp_pkg::PH_KEY);
        end else begin
          ps_idx++;
        end
      end
      krsp_pkg::PH_CAT: begin
        ps_cat[8*ps_idx[0] +: 8] = b;
        if (ps_idx[0]) begin
          ps_idx = 2'd0;
          ps_phase = ts_on ? krsp_pkg::PH_TS : krsp_pkg::PH_KEY;
        end else begin
          ps_idx = 2'd1;
        end
      end
      krsp_pkg::PH_TS: begin
        ps_ts[8*ps_idx +: 8] = b;
        if (ps_idx == 2'd3) begin
          ps_idx = 2'd0;
          ps_phase = krsp_pkg::PH_KEY;
        end else begin
          ps_idx++;
        end
      end
      default: begin
        if (b != 8'd0 && ps_count < KEY_CAP) ps_count++;
        r.record_id = ps_id;
        r.category = ps_cat;
        r.timestamp = ps_ts;
        r.key_byte = b;
        r.key_length = ps_count;
        r.record_end = (b == 8'd0);
        key_results_due.push_back(r);
        if (b == 8'd0) begin
          ps_phase = krsp_pkg::PH_ID;
          ps_idx = 2'd0;
          ps_count = 16'd0;
        end
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input bit start);
    krsp_pkg::in_payload_t p;
    p.data_byte = b;
    p.buffer_start = start;
    stream_bytes.push_back(p);
  endtask

  // Queues the header bytes of one record for the given field layout.
  task automatic push_header(input logic [31:0] id, input logic [15:0] cat,
                             input logic [31:0] ts, input bit with_cat,
                             input bit with_ts, input bit start);
    for (int i = 0; i < 4; i++) push_byte(id[8*i +: 8], start && i == 0);
    if (with_cat) for (int i = 0; i < 2; i++) push_byte(cat[8*i +: 8], 1'b0);
    if (with_ts) for (int i = 0; i < 4; i++) push_byte(ts[8*i +: 8], 1'b0);
  endtask

  // A well-formed record with random content; a broken one is cut short.
  task automatic push_random_record(input bit start, input bit broken);
    int klen;
    int total;
    int cut;
    klen = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 0);
    push_header($urandom, 16'($urandom), $urandom, cat_on, ts_on, start);
    for (int i = 0; i < klen; i++) push_byte(8'($urandom_range(255, 1)), 1'b0);
    push_byte(8'h00, 1'b0);
    if (broken) begin
      total = 5 + 2 * cat_on + 4 * ts_on + klen;
      cut = $urandom_range(total - 1, 1);
      repeat (total - cut) void'(stream_bytes.pop_back());
    end
  endtask

  // Returns once nothing is queued or owed, then waits on for the result register to drain.
  task automatic wait_idle();
    while (stream_bytes.size() != 0 || in_valid || key_results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Must be called right after a rising edge while the parser is idle.
  task automatic write_reg(input logic [krsp_pkg::CFG_INDEX_W-1:0] idx, input bit val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == krsp_pkg::CFG_CATEGORY_PRESENT) cat_on = val;
    else if (idx == krsp_pkg::CFG_TIMESTAMP_PRESENT) ts_on = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_layout(input bit with_cat, input bit with_ts);
    write_reg(krsp_pkg::CFG_CATEGORY_PRESENT, with_cat);
    write_reg(krsp_pkg::CFG_TIMESTAMP_PRESENT, with_ts);
    settings_used++;
  endtask

  // Driver: the transaction is predicted at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(in_payload);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (stream_bytes.size() == 0 || (!no_gaps && $urandom_range(99) < 9)) begin
          in_valid <= 1'b0;
        end else begin
          in_payload <= stream_bytes.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest owed one and drives the sink stall.
  int  rx_hold_left = 0;
  bit  rx_hold_done = 1'b0;

  always @(posedge clk) begin
    krsp_pkg::out_payload_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (key_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: id=%h key=%h end=%b", out_payload.record_id,
                     out_payload.key_byte, out_payload.record_end);
        end else begin
          want = key_results_due.pop_front();
          if (out_payload.record_id !== want.record_id || out_payload.category !== want.category
              || out_payload.timestamp !== want.timestamp
              || out_payload.key_byte !== want.key_byte
              || out_payload.key_length !== want.key_length
              || out_payload.record_end !== want.record_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected id=%h cat=%h ts=%0d key=%h len=%0d end=%b",
                       want.record_id, want.category, want.timestamp, want.key_byte,
                       want.key_length, want.record_end);
              $display("  actual   id=%h cat=%h ts=%0d key=%h len=%0d end=%b",
                       out_payload.record_id, out_payload.category, out_payload.timestamp,
                       out_payload.key_byte, out_payload.key_length, out_payload.record_end);
            end
          end
        end
      end
      // One long hold-off so the result register fills and the input backs up.
      if (!rx_hold_done && results_seen >= 150) begin
        rx_hold_done = 1'b1;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_gaps && ($urandom_range(99) < 9);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               key_results_due.size());
      $display("[key_record_stream_parser_core] ERROR");
      $finish;
    end
  end

  initial begin
    bit resync;
    int roll;
    int phase_end;
    bit cat_plan[RANDOM_PHASES];
    bit ts_plan[RANDOM_PHASES];

    cat_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    ts_plan  = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    ps_phase = krsp_pkg::PH_ID;
    ps_idx = '0;
    ps_id = '0;
    ps_cat = '0;
    ps_ts = '0;
    ps_count = '0;
    cat_on = 1'b0;
    ts_on = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset layout: id then key only. Extreme ids, an empty key, restarts mid-key and mid-id.
    settings_used++;
    push_header(32'hFFFF_FFFF, '0, '0, 1'b0, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    push_header(32'h0000_0000, '0, '0, 1'b0, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0);
    push_header(32'h0403_0201, '0, '0, 1'b0, 1'b0, 1'b0);
    push_byte(8'h41, 1'b0);
    push_header(32'h8000_007E, '0, '0, 1'b0, 1'b0, 1'b1);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b0);
    push_header(32'hA5A5_5A5A, '0, '0, 1'b0, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0);
    wait_idle();

    // Full layout with extreme category and timestamp; writes to spare indexes do nothing.
    set_layout(1'b1, 1'b1);
    write_reg(CFG_SPARE_2, 1'b1);
    write_reg(CFG_SPARE_3, 1'b1);
    push_header(32'h8000_0001, 16'hFFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h00, 1'b0);
    push_header(32'h7FFF_FFFE, 16'h0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0);
    wait_idle();

    // The layout changes after the id is complete: the category still follows, then the
    // timestamp that the new setting calls for.
    set_layout(1'b1, 1'b0);
    push_header(32'h1234_5678, '0, '0, 1'b0, 1'b0, 1'b0);
    wait_idle();
    set_layout(1'b0, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b0);
    push_header(32'hDEAD_BEEF, '0, '0, 1'b0, 1'b0, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(8'h00, 1'b0);
    wait_idle();

    // Random records, mostly well formed, with some cut short and some stray bytes.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_layout(cat_plan[ph], ts_plan[ph]);
      no_gaps = (ph == 2);
      resync = 1'b1;
      phase_end = BYTES_PER_PHASE;
      while (phase_end > 0) begin
        roll = $urandom_range(99);
        phase_end += stream_bytes.size();
        if (roll < 5) begin
          repeat ($urandom_range(6, 1)) push_byte(8'($urandom), $urandom_range(3) == 0);
          resync = 1'b1;
        end else begin
          push_random_record(resync || roll < 14, roll >= 88);
          resync = (roll >= 88);
        end
        phase_end -= stream_bytes.size();
      end
      wait_idle();
    end
    no_gaps = 1'b0;
    repeat (10) @(posedge clk);

    if (key_results_due.size() != 0) begin
      $display("%0d expected results never arrived", key_results_due.size());
      mismatches += key_results_due.size();
    end
    $display("Fed %0d bytes and checked %0d results over %0d field layouts,", bytes_taken,
             results_seen, settings_used);
    $display("with restarts, truncated records, stray bytes and a long sink hold-off.");
    if (mismatches == 0) begin
      $display("[key_record_stream_parser_core] OK");
    end else begin
      $display("[key_record_stream_parser_core] ERROR");
    end
    $finish;
  end

endmodule
